/* design/tbo_pkg.sv */
package tbo_pkg;

  localparam int unsigned KEY_BYTES = 32;
  localparam int unsigned PAD_BYTES = 16;
  localparam logic [7:0] UNENCRYPTED_FLAG = 8'h01;

  // Configuration register indexes
  localparam logic [2:0] CFG_KEY_LEN    = 3'd0;
  localparam logic [2:0] CFG_KEY_WORD_0 = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD_1 = 3'd2;
  localparam logic [2:0] CFG_KEY_WORD_2 = 3'd3;
  localparam logic [2:0] CFG_KEY_WORD_3 = 3'd4;

  localparam logic [31:0] MD5_IV_A = 32'h67452301;
  localparam logic [31:0] MD5_IV_B = 32'hefcdab89;
  localparam logic [31:0] MD5_IV_C = 32'h98badcfe;
  localparam logic [31:0] MD5_IV_D = 32'h10325476;

  typedef struct packed {
    logic [7:0]  body_byte;
    logic        first_byte;
    logic [31:0] session_ident;
    logic [7:0]  proto_version;
    logic [7:0]  sequence_number;
    logic [7:0]  flags_in;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] flags_out;
  } out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_st_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_r(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // Message word used by round i
  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

/* design/tbo_md5_round.sv */
module tbo_md5_round
  import tbo_pkg::*;
(
  input  md5_st_t     st_i,
  input  logic [5:0]  rnd_i,
  input  logic [31:0] word_i,
  output md5_st_t     st_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot;

  // Select the round function
  always_comb begin
    case (rnd_i[5:4])
      2'd0: f = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
      2'd1: f = (st_i.d & st_i.b) | (~st_i.d & st_i.c);
      2'd2: f = st_i.b ^ st_i.c ^ st_i.d;
      default: f = st_i.c ^ (st_i.b | ~st_i.d);
    endcase
  end

  // Add, rotate and shift the state words
  assign sum = st_i.a + f + md5_k(rnd_i) + word_i;
  assign rot = {sum, sum} << md5_r(rnd_i);

  assign st_o.a = st_i.d;
  assign st_o.d = st_i.c;
  assign st_o.c = st_i.b;
  assign st_o.b = st_i.b + rot[63:32];

endmodule

/* design/tacacs_body_obfuscation_unit.sv */
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  in_req_i  (in_t)
// out       output     out_valid_o / out_stall_i out_rsp_o (out_t)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A byte at a chunk start goes through these steps: load the message block, the 64 MD5
// rounds on the shared round unit, fold the digest, post the result.
// Other bytes and bytes with obfuscation off skip the rounds and go straight to posting.
// Reset clears key, pads, chunk position and chain; no clearing pass.
// A stalled output holds in its register; the input stalls until the result is posted.
module tacacs_body_obfuscation_unit
  import tbo_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FIN, ST_DONE} state_e;

  state_e       state_q;
  logic [5:0]   key_len_q;
  logic [255:0] key_q;
  logic [127:0] cur_pad_q;
  logic [3:0]   idx_q;
  logic         chain_q;
  logic [511:0] blk_q, blk_d;
  logic [5:0]   rnd_q;
  md5_st_t      st_q, st_d;
  out_t         res_q, out_q;
  logic         out_valid_q;
  logic [7:0]   body_q, flags_q;

  logic         in_acc, out_acc;
  logic [5:0]   klen;
  logic [3:0]   idx_eff;
  logic         chain_eff;
  logic [127:0] pad_new;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_q && !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Clamp the key length and apply a packet restart
  assign klen      = (key_len_q > 6'(KEY_BYTES)) ? 6'(KEY_BYTES) : key_len_q;
  assign idx_eff   = in_req_i.first_byte ? 4'd0 : idx_q;
  assign chain_eff = in_req_i.first_byte ? 1'b0 : chain_q;

  // Build the single message block, padding and length included
  always_comb begin
    logic [6:0] len_v;
    logic [9:0] bits_v;
    logic [6:0] pp;
    logic [6:0] koff;
    logic [6:0] poff;
    len_v  = 7'd6 + 7'(klen) + (chain_eff ? 7'd16 : 7'd0);
    bits_v = {len_v, 3'b000};
    for (int p = 0; p < 64; p++) begin
      pp   = 7'(p);
      koff = pp - 7'd4;
      poff = pp - 7'd6 - 7'(klen);
      if (pp < 7'd4) begin
        blk_d[8*p +: 8] = in_req_i.session_ident[8*(3-p) +: 8];
      end else if (pp < 7'd4 + 7'(klen)) begin
        blk_d[8*p +: 8] = key_q[8*koff[4:0] +: 8];
      end else if (pp == 7'd4 + 7'(klen)) begin
        blk_d[8*p +: 8] = in_req_i.proto_version;
      end else if (pp == 7'd5 + 7'(klen)) begin
        blk_d[8*p +: 8] = in_req_i.sequence_number;
      end else if (chain_eff && (pp < 7'd22 + 7'(klen))) begin
        blk_d[8*p +: 8] = cur_pad_q[8*poff[3:0] +: 8];
      end else if (pp == len_v) begin
        blk_d[8*p +: 8] = 8'h80;
      end else if (pp == 7'd56) begin
        blk_d[8*p +: 8] = bits_v[7:0];
      end else if (pp == 7'd57) begin
        blk_d[8*p +: 8] = {6'd0, bits_v[9:8]};
      end else begin
        blk_d[8*p +: 8] = 8'h00;
      end
    end
  end

  tbo_md5_round u_round (
    .st_i   (st_q),
    .rnd_i  (rnd_q),
    .word_i (blk_q[32*md5_g(rnd_q) +: 32]),
    .st_o   (st_d)
  );

  // Fold the digest into the chaining values
  assign pad_new = {st_q.d + MD5_IV_D, st_q.c + MD5_IV_C,
                    st_q.b + MD5_IV_B, st_q.a + MD5_IV_A};

  // Take register writes; sequence one byte: load, rounds, fold, post, or post directly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_len_q   <= '0;
      key_q       <= '0;
      cur_pad_q   <= '0;
      idx_q       <= '0;
      chain_q     <= 1'b0;
      blk_q       <= '0;
      rnd_q       <= '0;
      st_q        <= '0;
      res_q       <= '0;
      out_q       <= '0;
      body_q      <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_KEY_LEN:    key_len_q       <= cfg_data_i[5:0];
          CFG_KEY_WORD_0: key_q[63:0]     <= cfg_data_i;
          CFG_KEY_WORD_1: key_q[127:64]   <= cfg_data_i;
          CFG_KEY_WORD_2: key_q[191:128]  <= cfg_data_i;
          CFG_KEY_WORD_3: key_q[255:192]  <= cfg_data_i;
          default: ;
        endcase
      end
      // Post a finished result or drop a taken one
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_req_i.first_byte) begin
              idx_q   <= 4'd0;
              chain_q <= 1'b0;
            end
            if (klen == 6'd0) begin
              res_q   <= '{out_byte: in_req_i.body_byte, flags_out: in_req_i.flags_in};
              state_q <= ST_DONE;
            end else if (idx_eff == 4'd0) begin
              blk_q      <= blk_d;
              body_q     <= in_req_i.body_byte;
              flags_q    <= in_req_i.flags_in;
              st_q       <= '{a: MD5_IV_A, b: MD5_IV_B, c: MD5_IV_C, d: MD5_IV_D};
              rnd_q      <= 6'd0;
              state_q    <= ST_ROUND;
            end else begin
              res_q   <= '{out_byte: in_req_i.body_byte ^ cur_pad_q[8*idx_eff +: 8],
                           flags_out: in_req_i.flags_in ^ UNENCRYPTED_FLAG};
              idx_q   <= idx_eff + 4'd1;
              state_q <= ST_DONE;
            end
          end
        end
        ST_ROUND: begin
          st_q  <= st_d;
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= ST_FIN;
        end
        ST_FIN: begin
          cur_pad_q <= pad_new;
          chain_q   <= 1'b1;
          idx_q     <= 4'd1;
          res_q     <= '{out_byte: body_q ^ pad_new[7:0],
                         flags_out: flags_q ^ UNENCRYPTED_FLAG};
          state_q   <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Rounds run without a break until the last one
  a_round_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q != 6'd63) |=> (state_q == ST_ROUND))
    else $error("round sequence broke early");

  // A folded digest always starts the chain
  a_fin_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |=> (chain_q && idx_q == 4'd1 && state_q == ST_DONE))
    else $error("digest fold did not update chain");

  // A waiting result is never dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result lost");

endmodule

/* bench/obfuscation_checker.sv */
`timescale 1ns / 100ps

// Watch the request, response and register channels, predict each response and compare.
module obfuscation_checker
  import tbo_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_rsp_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Shadow registers and chaining state
  logic [5:0]  key_len;
  logic [63:0] key_word [0:3];
  logic [7:0]  prev_pad [0:15];
  logic [7:0]  cur_pad  [0:15];
  logic [3:0]  chunk_pos;
  logic        chained;

  out_t        expected_q [$];
  int          fail_count;

  // MD5 tables and the message buffer of the pad hash
  logic [31:0] sine_k [0:63];
  int          rot_amt [0:15];
  logic [7:0]  hash_msg [0:127];

  initial begin
    real s;
    int rots [0:15];
    rots = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    for (int i = 0; i < 64; i++) begin
      s = $sin(i + 1);
      if (s < 0.0) s = -s;
      sine_k[i] = 32'(longint'($floor(s * 4294967296.0)));
    end
    for (int i = 0; i < 16; i++) rot_amt[i] = rots[i];
  end

  // Hash the first len bytes of hash_msg into cur_pad
  function automatic void hash_into_pad(input int len);
    logic [7:0]  blk [0:127];
    logic [31:0] h [0:3];
    logic [31:0] w [0:15];
    logic [31:0] a, b, c, d, f, t, sum;
    logic [63:0] nbits;
    int total, g, r;
    h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
    total = ((len + 9 + 63) / 64) * 64;
    nbits = 64'(len) * 8;
    for (int i = 0; i < 128; i++) blk[i] = (i < len) ? hash_msg[i] : 8'h00;
    blk[len] = 8'h80;
    for (int i = 0; i < 8; i++) blk[total - 8 + i] = nbits[8*i +: 8];
    for (int base = 0; base < total; base += 64) begin
      for (int i = 0; i < 16; i++)
        w[i] = {blk[base+4*i+3], blk[base+4*i+2], blk[base+4*i+1], blk[base+4*i]};
      a = h[0]; b = h[1]; c = h[2]; d = h[3];
      for (int i = 0; i < 64; i++) begin
        if (i < 16) begin
          f = (b & c) | (~b & d); g = i;
        end else if (i < 32) begin
          f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
        end else if (i < 48) begin
          f = b ^ c ^ d; g = (3 * i + 5) % 16;
        end else begin
          f = c ^ (b | ~d); g = (7 * i) % 16;
        end
        r = rot_amt[((i / 16) * 4) + (i % 4)];
        sum = a + f + sine_k[i] + w[g];
        t = d; d = c; c = b;
        b = b + ((sum << r) | (sum >> (32 - r)));
        a = t;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d;
    end
    for (int i = 0; i < 16; i++) cur_pad[i] = h[i / 4][8*(i % 4) +: 8];
  endfunction

  // Advance the pad chain by one body byte and return the obfuscated byte
  function automatic out_t obfuscate_byte(input in_t req);
    out_t res;
    int eff_len, n;
    eff_len = (key_len > KEY_BYTES) ? KEY_BYTES : int'(key_len);
    if (req.first_byte) begin
      chunk_pos = '0;
      chained = 1'b0;
    end
    if (eff_len == 0) begin
      res.out_byte = req.body_byte;
      res.flags_out = req.flags_in;
      return res;
    end
    if (chunk_pos == 0) begin
      prev_pad = cur_pad;
      n = 0;
      for (int i = 3; i >= 0; i--) begin
        hash_msg[n] = req.session_ident[8*i +: 8]; n++;
      end
      for (int k = 0; k < eff_len; k++) begin
        hash_msg[n] = key_word[k / 8][8*(k % 8) +: 8]; n++;
      end
      hash_msg[n] = req.proto_version; n++;
      hash_msg[n] = req.sequence_number; n++;
      if (chained) begin
        for (int i = 0; i < 16; i++) hash_msg[n + i] = prev_pad[i];
        n += 16;
      end
      hash_into_pad(n);
      chained = 1'b1;
    end
    res.out_byte = req.body_byte ^ cur_pad[chunk_pos];
    res.flags_out = req.flags_in ^ UNENCRYPTED_FLAG;
    chunk_pos = chunk_pos + 4'd1;
    return res;
  endfunction

  // Track register writes, predict requests, compare responses
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      key_len = '0;
      for (int i = 0; i < 4; i++) key_word[i] = '0;
      for (int i = 0; i < 16; i++) begin
        prev_pad[i] = '0;
        cur_pad[i] = '0;
      end
      chunk_pos = '0;
      chained = 1'b0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_KEY_LEN:    key_len = cfg_data_i[5:0];
          CFG_KEY_WORD_0: key_word[0] = cfg_data_i;
          CFG_KEY_WORD_1: key_word[1] = cfg_data_i;
          CFG_KEY_WORD_2: key_word[2] = cfg_data_i;
          CFG_KEY_WORD_3: key_word[3] = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(obfuscate_byte(in_req_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected response out_byte=%h flags_out=%h",
                 out_rsp_i.out_byte, out_rsp_i.flags_out);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_rsp_i.out_byte !== want.out_byte) begin
            $error("out_byte expected %h actual %h", want.out_byte, out_rsp_i.out_byte);
            fail_count++;
          end
          if (out_rsp_i.flags_out !== want.flags_out) begin
            $error("flags_out expected %h actual %h", want.flags_out, out_rsp_i.flags_out);
            fail_count++;
          end
        end
      end
    end
  end

  assign fail_count_o = fail_count;
  assign pending_o = expected_q.size();

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import tbo_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_KEY_LEN;
  logic [63:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_max = 0;
  int          stall_mode = 0;
  int          stall_cnt = 0;

  tacacs_body_obfuscation_unit u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_rsp_o(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  obfuscation_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_rsp_i(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the response channel on a pattern picked at random from four modes
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_cnt / 8) % 2 == 1);
    endcase
  end

  // End the run when no channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Hold one request until it is taken, then maybe open a gap
  task automatic send_request(input in_t req);
    int gap;
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] body, input logic first, input logic [31:0] sid,
                           input logic [7:0] ver, input logic [7:0] seq, input logic [7:0] flags);
    in_t req;
    req.body_byte = body;
    req.first_byte = first;
    req.session_ident = sid;
    req.proto_version = ver;
    req.sequence_number = seq;
    req.flags_in = flags;
    send_request(req);
  endtask

  // Send a packet body of len random bytes under one header
  task automatic send_packet(input int len, input logic [31:0] sid, input logic [7:0] ver,
                             input logic [7:0] seq, input logic [7:0] flags);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom), i == 0, sid, ver, seq, flags);
  endtask

  // Drain all responses, let the block settle, then write one register
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_key(input logic [5:0] len, input logic [63:0] w0, input logic [63:0] w1,
                           input logic [63:0] w2, input logic [63:0] w3);
    write_reg(CFG_KEY_WORD_0, w0);
    write_reg(CFG_KEY_WORD_1, w1);
    write_reg(CFG_KEY_WORD_2, w2);
    write_reg(CFG_KEY_WORD_3, w3);
    write_reg(CFG_KEY_LEN, 64'(len));
  endtask

  function automatic logic [63:0] rand64();
    return {32'($urandom), 32'($urandom)};
  endfunction

  initial begin
    int sent;
    int len;
    logic [31:0] sid;
    logic [7:0] ver, seq, flags;
    logic [5:0] klen;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Disabled after reset: bytes and flags pass through
    send_byte(8'h00, 1'b0, 32'h0, 8'h00, 8'h00, 8'h00);
    send_byte(8'hff, 1'b1, 32'hffffffff, 8'hff, 8'hff, 8'hff);

    // No first-byte marker after a key is set: start of packet implied
    write_key(6'd32, '1, '1, '1, '1);
    send_byte(8'hff, 1'b0, 32'hffffffff, 8'hff, 8'hff, 8'hff);
    send_byte(8'h00, 1'b0, 32'hffffffff, 8'hff, 8'hff, 8'hfe);
    // Header fields changing inside a packet cross a chunk boundary
    for (int i = 0; i < 17; i++)
      send_byte(8'($urandom), i == 0, 32'h1234_5678 + i, 8'(i), 8'(255 - i), 8'($urandom));

    // Key length change inside a chunk: a nonzero length waits for the next chunk, zero bypasses at once
    write_key(6'd1, 64'h5a, '0, '0, '0);
    send_packet(15, 32'h0, 8'hc0, 8'h01, 8'h01);
    write_reg(CFG_KEY_LEN, 64'd63);
    send_byte(8'h3c, 1'b0, 32'h0, 8'hc0, 8'h01, 8'h01);
    write_reg(CFG_KEY_LEN, 64'd0);
    send_byte(8'h3c, 1'b0, 32'h0, 8'hc0, 8'h01, 8'h01);
    sent = 0;

    // Random phases with fresh keys, mostly well-formed packets
    while (sent < 1450) begin
      case ($urandom_range(0, 5))
        0: klen = 6'd0;
        1: klen = 6'd32;
        2: klen = 6'($urandom_range(33, 63));
        3: klen = 6'd1;
        default: klen = 6'($urandom_range(1, 31));
      endcase
      write_key(klen, rand64(), rand64(), rand64(), rand64());
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      for (int p = 0; p < 8 && sent < 1450; p++) begin
        sid = $urandom;
        ver = 8'($urandom);
        seq = 8'($urandom);
        flags = 8'($urandom);
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 20);
        if ($urandom_range(0, 5) == 0) begin
          // Noise: arbitrary markers and header fields per byte
          for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom), 1'($urandom), $urandom, 8'($urandom), 8'($urandom),
                      8'($urandom));
          end
        end else begin
          send_packet(len, sid, ver, seq, flags);
        end
        sent += len;
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
design/tbo_pkg.sv
design/tbo_md5_round.sv
design/tacacs_body_obfuscation_unit.sv
bench/obfuscation_checker.sv
bench/testbench.sv
